>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lsq_pkg.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue package
// Field widths, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
package lsq_pkg;

	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   value;
		logic [DATA_W-1:0]   prio;
	} result_t;

endpackage

>>> rtl/core/linear_scan_priority_queue.sv
// ----------------------------------------------------------------------------
// Linear scan priority queue
// Unsorted array of value and priority pairs with insert, peek and delete.
// ----------------------------------------------------------------------------
// Usage: an input word (mode, item_value, item_priority) is taken when in_valid
// is high and in_stall is low. Each word yields exactly one result word
// (status, found_position, found_value, found_priority), taken when out_valid
// is high and out_stall is low. The capacity register is written through
// cfg_valid and cfg_ready with capacity_limit as data; cfg_ready is always high.
// Insert, refused insert, empty peek or delete, and the unused mode go from
// idle straight to the done state. A peek reads every entry through the
// single RAM read port, feeding the shared comparator one entry per cycle.
// A delete then moves each entry above the winner down through the same
// read port and lowers the entry count. One word is in work at a time;
// in_stall is high until its result moves into the output register.
// A stalled receiver holds the result in the output register and the next
// word may still be accepted and worked on behind it.
// Reset empties the queue and sets the capacity to 16; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_scan_priority_queue #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lsq_pkg::MODE_W-1:0]          mode,
	input  logic signed [lsq_pkg::DATA_W-1:0]   item_value,
	input  logic signed [lsq_pkg::DATA_W-1:0]   item_priority,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lsq_pkg::STATUS_W-1:0]        status,
	output logic [lsq_pkg::POS_W-1:0]           found_position,
	output logic signed [lsq_pkg::DATA_W-1:0]   found_value,
	output logic signed [lsq_pkg::DATA_W-1:0]   found_priority,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsq_pkg::CAP_W-1:0]           capacity_limit
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	logic [lsq_pkg::CAP_W-1:0] cap_q;
	logic                      out_valid_q;
	lsq_pkg::result_t          out_res_q;

	logic                      busy;
	logic                      res_valid;
	lsq_pkg::result_t          res;
	logic                      res_take;
	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	lsq_pkg::entry_t           wr_data;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	lsq_pkg::entry_t           rd_data;

	assign in_stall  = busy;
	assign cfg_ready = 1'b1;
	assign res_take  = res_valid && (!out_valid_q || !out_stall);

	lsq_seq #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && !in_stall),
		.mode          (mode),
		.item_value    (item_value),
		.item_priority (item_priority),
		.cap           (cap_q),
		.res_take      (res_take),
		.busy          (busy),
		.res_valid     (res_valid),
		.res           (res),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	lsq_ram #(
		.WIDTH ($bits(lsq_pkg::entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lsq_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity_limit;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign found_position = out_res_q.position;
	assign found_value    = out_res_q.value;
	assign found_priority = out_res_q.prio;

	`ASSERT_NEXT(a_accept_holds_off, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_IMPLIES(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall))
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid, status == lsq_pkg::STATUS_OK || status == lsq_pkg::STATUS_EMPTY || status == lsq_pkg::STATUS_FULL)
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, out_valid && status != lsq_pkg::STATUS_OK, found_value == '0 && found_priority == '0 && found_position == '0)

endmodule

>>> rtl/core/lsq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/lsq_cmp.sv
// ----------------------------------------------------------------------------
// Entry comparator
// Tells whether a candidate entry beats the current best entry.
// ----------------------------------------------------------------------------
module lsq_cmp (
	input  lsq_pkg::entry_t cand,
	input  lsq_pkg::entry_t best,
	output logic            better
);

	logic prio_gt;
	logic prio_eq;
	logic value_gt;

	assign prio_gt  = $signed(cand.prio) > $signed(best.prio);
	assign prio_eq  = cand.prio == best.prio;
	assign value_gt = $signed(cand.value) > $signed(best.value);
	assign better   = prio_gt || (prio_eq && value_gt);

endmodule

>>> rtl/core/lsq_seq.sv
// ----------------------------------------------------------------------------
// Queue sequencer
// Runs insert, scan and shift steps over the entry RAM with one comparator.
// ----------------------------------------------------------------------------
module lsq_seq #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lsq_pkg::MODE_W-1:0]        mode,
	input  logic [lsq_pkg::DATA_W-1:0]        item_value,
	input  logic [lsq_pkg::DATA_W-1:0]        item_priority,
	input  logic [lsq_pkg::CAP_W-1:0]         cap,
	input  logic                              res_take,
	output logic                              busy,
	output logic                              res_valid,
	output lsq_pkg::result_t                  res,
	output logic                              wr_en,
	output logic [$clog2(MAX_ENTRIES)-1:0]    wr_addr,
	output lsq_pkg::entry_t                   wr_data,
	output logic                              rd_en,
	output logic [$clog2(MAX_ENTRIES)-1:0]    rd_addr,
	input  lsq_pkg::entry_t                   rd_data
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CW    = (CNT_W > lsq_pkg::CAP_W) ? CNT_W : lsq_pkg::CAP_W;
	localparam int PX_W  = IDX_W + lsq_pkg::POS_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    ridx_q;
	logic                pend_s1;
	logic [IDX_W-1:0]    pidx_s1;
	logic                first_q;
	logic                del_q;
	lsq_pkg::entry_t     best_q;
	logic [IDX_W-1:0]    best_pos_q;
	lsq_pkg::result_t    res_q;

	logic                full;
	logic                empty;
	logic                more_rd;
	logic                better;
	logic [CNT_W-1:0]    next_pos;
	logic                is_insert;
	logic                is_find;
	logic [PX_W-1:0]     pos_ext;

	assign full      = (CW'(count_q) >= CW'(cap)) || (count_q == CNT_W'(MAX_ENTRIES));
	assign empty     = count_q == '0;
	assign more_rd   = ridx_q < count_q;
	assign next_pos  = CNT_W'(best_pos_q) + CNT_W'(1);
	assign is_insert = mode == lsq_pkg::MODE_INSERT;
	assign is_find   = (mode == lsq_pkg::MODE_PEEK) || (mode == lsq_pkg::MODE_DELETE);
	assign pos_ext   = PX_W'(best_pos_q);

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	lsq_cmp u_cmp (
		.cand   (rd_data),
		.best   (best_q),
		.better (better)
	);

	always_comb begin
		rd_en         = 1'b0;
		rd_addr       = ridx_q[IDX_W-1:0];
		wr_en         = 1'b0;
		wr_addr       = count_q[IDX_W-1:0];
		wr_data.value = item_value;
		wr_data.prio  = item_priority;
		unique case (state_q)
			S_IDLE: begin
				if (start && is_insert && !full) begin
					wr_en = 1'b1;
				end
				if (start && is_find && !empty) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_SCAN: begin
				if (more_rd) begin
					rd_en = 1'b1;
				end else if (!pend_s1 && del_q && (next_pos < count_q)) begin
					rd_en   = 1'b1;
					rd_addr = next_pos[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				if (more_rd) begin
					rd_en = 1'b1;
				end
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = pidx_s1 - IDX_W'(1);
					wr_data = rd_data;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ridx_q  <= '0;
			pend_s1 <= 1'b0;
			first_q <= 1'b0;
			del_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (is_insert) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end else if (is_find && !empty) begin
							ridx_q  <= CNT_W'(1);
							pend_s1 <= 1'b1;
							first_q <= 1'b1;
							del_q   <= mode == lsq_pkg::MODE_DELETE;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (more_rd) begin
						ridx_q  <= ridx_q + CNT_W'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1) begin
						first_q <= 1'b0;
					end else if (del_q) begin
						state_q <= S_SHIFT;
						if (next_pos < count_q) begin
							pend_s1 <= 1'b1;
							ridx_q  <= next_pos + CNT_W'(1);
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (more_rd) begin
						ridx_q  <= ridx_q + CNT_W'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (!pend_s1) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pidx_s1 <= rd_addr;
		end
		if ((state_q == S_SCAN) && pend_s1 && (first_q || better)) begin
			best_q     <= rd_data;
			best_pos_q <= pidx_s1;
		end
		if ((state_q == S_IDLE) && start) begin
			res_q <= '0;
			if (is_insert) begin
				res_q.status <= full ? lsq_pkg::STATUS_FULL : lsq_pkg::STATUS_OK;
			end else if (is_find) begin
				res_q.status <= lsq_pkg::STATUS_EMPTY;
			end
		end else if ((state_q == S_SCAN) && !pend_s1) begin
			res_q.status   <= lsq_pkg::STATUS_OK;
			res_q.position <= pos_ext[lsq_pkg::POS_W-1:0];
			res_q.value    <= best_q.value;
			res_q.prio     <= best_q.prio;
		end
	end

endmodule
